// ===== design/gbpe_pkg.sv =====
// Shared types and constants for the glyph bitmap pixel expander.
package gbpe_pkg;

  localparam int unsigned PixPerByte   = 8;
  localparam int unsigned ByteW        = 8;
  localparam int unsigned ColorW       = 16;
  localparam int unsigned DimW         = 8;
  localparam int unsigned IndexW       = 16;
  localparam int unsigned CountW       = $clog2(PixPerByte + 1);
  localparam int unsigned BitPosW      = $clog2(PixPerByte);
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned FifoDepthDef = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegGlyphWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGlyphHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] RegForeColor   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBackColor   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegDrawMode    = 3'd4;

  // Draw mode codes; the unused code draws as opaque.
  localparam logic [1:0] ModeOpaque      = 2'd0;
  localparam logic [1:0] ModeTransparent = 2'd1;
  localparam logic [1:0] ModeInverse     = 2'd2;

  // Colors and mode seen by the pixel stage.
  typedef struct packed {
    logic [ColorW-1:0] fore_color;
    logic [ColorW-1:0] backdrop_color;
    logic [1:0]        draw_mode;
  } color_cfg_t;

  // One classified byte waiting to be drawn.
  typedef struct packed {
    logic [ByteW-1:0]  font_byte;
    logic [CountW-1:0] count;
    logic              ends_glyph;
  } job_t;

endpackage

// ===== design/gbpe_front.sv =====
// Front stage: accepts bitmap bytes and works out how many pixels each one owes.
module gbpe_front import gbpe_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] glyph_width_i,
  input  logic [DimW-1:0] glyph_height_i,
  input  logic            in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  output logic            in_ready_o,
  input  logic            q_full_i,
  output logic            q_push_o,
  output job_t            q_job_o
);

  logic [IndexW-1:0] pixel_index_q, pixel_index_d;
  logic [IndexW-1:0] total;
  logic [IndexW-1:0] base;
  logic [IndexW-1:0] remaining;
  logic [CountW-1:0] count;
  logic              ends_glyph;
  logic              accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Glyph size and the pixels still owed for the current glyph.
  always_comb begin
    total      = IndexW'(glyph_width_i) * IndexW'(glyph_height_i);
    base       = (pixel_index_q >= total) ? '0 : pixel_index_q;
    remaining  = total - base;
    count      = (remaining < IndexW'(PixPerByte)) ? remaining[CountW-1:0]
                                                    : CountW'(PixPerByte);
    ends_glyph = (IndexW'(count) == remaining) && (count != '0);
  end

  // Bytes that owe no pixel are taken and dropped.
  assign q_push_o = accept && (count != '0);
  assign q_job_o  = '{font_byte: in_byte_i, count: count, ends_glyph: ends_glyph};

  // Pixel counter restarts after the byte that completes the glyph.
  always_comb begin
    pixel_index_d = pixel_index_q;
    if (accept) begin
      pixel_index_d = ends_glyph ? '0 : base + IndexW'(count);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_index_q <= '0;
    end else begin
      pixel_index_q <= pixel_index_d;
    end
  end

endmodule

// ===== design/gbpe_fifo.sv =====
// Short queue of classified bytes between the front and pixel stages.
module gbpe_fifo import gbpe_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t head_job_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            do_push, do_pop;

  assign full_o     = (fill_q == CntW'(Depth));
  assign valid_o    = (fill_q != '0);
  assign head_job_o = entries_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// ===== design/gbpe_back.sv =====
// Pixel stage: walks the bits of the queued byte and drives the output register.
module gbpe_back import gbpe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  color_cfg_t        cfg_i,
  input  logic              q_valid_i,
  input  job_t              q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ColorW-1:0] out_color_o,
  output logic              out_keep_o,
  output logic              out_last_byte_o,
  output logic              out_glyph_done_o
);

  logic [BitPosW-1:0] bit_pos_q, bit_pos_d;
  logic               out_valid_q, out_valid_d;
  logic [ColorW-1:0]  color_q, color_d;
  logic               keep_q, keep_d;
  logic               last_byte_q;
  logic               glyph_done_q;
  logic               advance;
  logic               last_pix;

  assign advance  = q_valid_i && (!out_valid_q || out_ready_i);
  assign last_pix = ((CountW'(bit_pos_q) + 1'b1) == q_job_i.count);
  assign q_pop_o  = advance && last_pix;

  // Color of the current pixel.
  always_comb begin
    color_d = cfg_i.backdrop_color;
    keep_d  = 1'b0;
    if (q_job_i.font_byte[bit_pos_q]) begin
      color_d = cfg_i.fore_color;
    end else begin
      case (cfg_i.draw_mode)
        ModeTransparent: begin
          color_d = '0;
          keep_d  = 1'b1;
        end
        ModeInverse: color_d = ~cfg_i.fore_color;
        default:     color_d = cfg_i.backdrop_color;
      endcase
    end
  end

  // Bit position and output handshake.
  always_comb begin
    bit_pos_d   = bit_pos_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      bit_pos_d   = last_pix ? '0 : bit_pos_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      bit_pos_q   <= bit_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      color_q      <= color_d;
      keep_q       <= keep_d;
      last_byte_q  <= last_pix;
      glyph_done_q <= last_pix && q_job_i.ends_glyph;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_color_o      = color_q;
  assign out_keep_o       = keep_q;
  assign out_last_byte_o  = last_byte_q;
  assign out_glyph_done_o = glyph_done_q;

endmodule

// ===== design/glyph_bitmap_pixel_expander.sv =====
// Top level of the glyph bitmap pixel expander.
// Each accepted bitmap byte is expanded, bit 0 first, into one 16-bit pixel per
// cycle while the output is not stalled, so a full byte gives eight pixels and
// the last byte of a glyph as many as the glyph has left; the pixel stage, which
// emits one pixel each cycle unless stalled, sets the sustained rate. Bytes are
// taken every cycle while the queue in front of the pixel stage has room, and a
// byte that owes no pixel (zero-size glyph) is taken and dropped. The pixel
// counter runs against width times height and restarts after the byte that ends
// a glyph, which is flagged on m_axis_tlast. Configuration writes take effect on
// the next cycle and are meant for idle periods only.
module glyph_bitmap_pixel_expander import gbpe_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] font_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,  // [15:0] pixel_color
  output logic                m_axis_tlast,  // glyph_done
  output logic [1:0]          m_axis_tuser,  // [0] keep_existing, [1] last_of_byte
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [DimW-1:0] glyph_width_q;
  logic [DimW-1:0] glyph_height_q;
  color_cfg_t      color_cfg_q;
  logic            q_full, q_push, q_pop, q_valid;
  job_t            q_in_job, q_head_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q              <= DimW'(8);
      glyph_height_q             <= DimW'(8);
      color_cfg_q.fore_color     <= '1;
      color_cfg_q.backdrop_color <= '0;
      color_cfg_q.draw_mode      <= ModeOpaque;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGlyphWidth:  glyph_width_q              <= cfg_data_i[DimW-1:0];
        RegGlyphHeight: glyph_height_q             <= cfg_data_i[DimW-1:0];
        RegForeColor:   color_cfg_q.fore_color     <= cfg_data_i[ColorW-1:0];
        RegBackColor:   color_cfg_q.backdrop_color <= cfg_data_i[ColorW-1:0];
        RegDrawMode:    color_cfg_q.draw_mode      <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  gbpe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .glyph_width_i  (glyph_width_q),
    .glyph_height_i (glyph_height_q),
    .in_valid_i     (s_axis_tvalid),
    .in_byte_i      (s_axis_tdata),
    .in_ready_o     (s_axis_tready),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .q_job_o        (q_in_job)
  );

  gbpe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (q_in_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_job_o (q_head_job)
  );

  gbpe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (color_cfg_q),
    .q_valid_i        (q_valid),
    .q_job_i          (q_head_job),
    .q_pop_o          (q_pop),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_color_o      (m_axis_tdata),
    .out_keep_o       (m_axis_tuser[0]),
    .out_last_byte_o  (m_axis_tuser[1]),
    .out_glyph_done_o (m_axis_tlast)
  );

endmodule

// ===== design/gbpe_checker.sv =====
// Port-level checks for the glyph bitmap pixel expander, bound to the top level.
module gbpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [1:0]  m_axis_tuser
);

  // The end of a glyph is always the last pixel of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("glyph end without byte end");

  // A kept pixel carries a zero color.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0))
    else $error("kept pixel with nonzero color");

  // A stalled pixel stays offered unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled pixel changed");

  // Without pixels leaving, a pixel is not withdrawn by an incoming byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output lost while input taken");

endmodule

bind glyph_bitmap_pixel_expander gbpe_checker u_gbpe_checker (.*);
